/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define IPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/ipd_pkg.sv */
// Shared types and constants for the pulse-distance IR decoder.
package ipd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD_LOW,
    PH_LEAD_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_LEAD_LOW,
    ST_BAD_LEAD_HIGH,
    ST_SHORT_BIT_LOW
  } status_e;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER_LOW_MIN,
    CFG_LEADER_LOW_MAX,
    CFG_LEADER_HIGH_MIN,
    CFG_LEADER_HIGH_MAX,
    CFG_BIT_LOW_MIN,
    CFG_ZERO_HIGH_MIN,
    CFG_ZERO_HIGH_MAX,
    CFG_ONE_HIGH_MIN
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] leader_low_min;
    logic [CFG_W-1:0] leader_low_max;
    logic [CFG_W-1:0] leader_high_min;
    logic [CFG_W-1:0] leader_high_max;
    logic [CFG_W-1:0] bit_low_min;
    logic [CFG_W-1:0] zero_high_min;
    logic [CFG_W-1:0] zero_high_max;
    logic [CFG_W-1:0] one_high_min;
  } cfg_t;

  localparam logic [CFG_W-1:0] RST_LEADER_LOW_MIN  = 16'd8500;
  localparam logic [CFG_W-1:0] RST_LEADER_LOW_MAX  = 16'd11000;
  localparam logic [CFG_W-1:0] RST_LEADER_HIGH_MIN = 16'd3500;
  localparam logic [CFG_W-1:0] RST_LEADER_HIGH_MAX = 16'd4500;
  localparam logic [CFG_W-1:0] RST_BIT_LOW_MIN     = 16'd1500;
  localparam logic [CFG_W-1:0] RST_ZERO_HIGH_MIN   = 16'd1500;
  localparam logic [CFG_W-1:0] RST_ZERO_HIGH_MAX   = 16'd2500;
  localparam logic [CFG_W-1:0] RST_ONE_HIGH_MIN    = 16'd3000;

  // Fixed exclusive upper bound of a one-bit high.
  localparam logic [CFG_W-1:0] ONE_HIGH_LIMIT = 16'd5000;

  localparam logic [3:0] BIT_IDX_LAST       = 4'd15;
  localparam logic [3:0] BIT_IDX_FIRST_BYTE = 4'd7;

  localparam int FIFO_DEPTH = 4;

endpackage

/* hdl/ipd_front.sv */
// Front end: takes pin samples, measures run lengths, posts one event per edge.
module ipd_front import ipd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  pin_level_i,
  input  logic                  fifo_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output logic                  ev_level_o,
  output logic [COUNT_BITS-1:0] ev_len_o
);

  logic                  prev_q, prev_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  accept;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  // Event carries the level of the run that just ended and its length.
  assign push_o     = accept && (pin_level_i != prev_q);
  assign ev_level_o = prev_q;
  assign ev_len_o   = cnt_q;

  always_comb begin
    prev_d = prev_q;
    cnt_d  = cnt_q;
    if (accept) begin
      prev_d = pin_level_i;
      if (pin_level_i != prev_q) begin
        cnt_d = COUNT_BITS'(1);
      end else if (cnt_q != {COUNT_BITS{1'b1}}) begin
        cnt_d = cnt_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* hdl/ipd_fifo.sv */
// Short event queue between front end and frame decoder.
module ipd_fifo import ipd_pkg::*; #(
  parameter int DATA_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] head_o,
  output logic              full_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/ipd_back.sv */
// Back end: frame state machine over edge events, result output register.
module ipd_back import ipd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  ev_valid_i,
  input  logic                  ev_level_i,
  input  logic [COUNT_BITS-1:0] ev_len_i,
  output logic                  ev_pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [1:0]            status_o,
  output logic [7:0]            first_byte_o,
  output logic [7:0]            second_byte_o
);

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] low_len_q, low_len_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            held_q, held_d;
  logic [3:0]            bit_idx_q, bit_idx_d;

  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [7:0]            first_q, first_d;
  logic [7:0]            second_q, second_d;

  logic [CMP_W-1:0] len_w, low_len_w;
  logic             lead_low_bad, lead_high_bad, bit_low_short, one_hit;
  logic [7:0]       shift_next;
  logic             emit;

  assign ev_pop_o = ev_valid_i && (!out_valid_q || !out_stall_i);

  assign len_w     = CMP_W'(ev_len_i);
  assign low_len_w = CMP_W'(low_len_q);

  assign lead_low_bad  = (len_w < CMP_W'(cfg_i.leader_low_min)) ||
                         (len_w > CMP_W'(cfg_i.leader_low_max));
  assign lead_high_bad = (len_w < CMP_W'(cfg_i.leader_high_min)) ||
                         (len_w > CMP_W'(cfg_i.leader_high_max));
  assign bit_low_short = low_len_w < CMP_W'(cfg_i.bit_low_min);
  assign one_hit       = (len_w > CMP_W'(cfg_i.one_high_min)) &&
                         (len_w < CMP_W'(ONE_HIGH_LIMIT));
  // A high in the zero window, or in no window, leaves bit 7 clear.
  assign shift_next    = {one_hit, shift_q[7:1]};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (ev_pop_o) begin
      case (phase_q)
        PH_LEAD_LOW: begin
          phase_d = lead_low_bad ? PH_IDLE : PH_LEAD_HIGH;
        end
        PH_LEAD_HIGH: begin
          phase_d = lead_high_bad ? PH_IDLE : PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          phase_d = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          if (bit_low_short || bit_idx_q >= BIT_IDX_LAST) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_BIT_LOW;
          end
        end
        default: begin
          // a high run ending is a falling edge
          phase_d = ev_level_i ? PH_LEAD_LOW : PH_IDLE;
        end
      endcase
    end
  end

  // Datapath and results
  always_comb begin
    low_len_d = low_len_q;
    shift_d   = shift_q;
    held_d    = held_q;
    bit_idx_d = bit_idx_q;
    emit      = 1'b0;
    status_d  = status_q;
    first_d   = first_q;
    second_d  = second_q;
    if (ev_pop_o) begin
      case (phase_q)
        PH_LEAD_LOW: begin
          if (lead_low_bad) begin
            emit     = 1'b1;
            status_d = ST_BAD_LEAD_LOW;
            first_d  = '0;
            second_d = '0;
          end
        end
        PH_LEAD_HIGH: begin
          if (lead_high_bad) begin
            emit     = 1'b1;
            status_d = ST_BAD_LEAD_HIGH;
            first_d  = '0;
            second_d = '0;
          end else begin
            bit_idx_d = '0;
            shift_d   = '0;
            held_d    = '0;
          end
        end
        PH_BIT_LOW: begin
          low_len_d = ev_len_i;
        end
        PH_BIT_HIGH: begin
          if (bit_low_short) begin
            emit     = 1'b1;
            status_d = ST_SHORT_BIT_LOW;
            first_d  = '0;
            second_d = '0;
          end else if (bit_idx_q >= BIT_IDX_LAST) begin
            shift_d   = shift_next;
            bit_idx_d = '0;
            emit      = 1'b1;
            status_d  = ST_OK;
            first_d   = held_q;
            second_d  = shift_next;
          end else begin
            bit_idx_d = bit_idx_q + 4'd1;
            if (bit_idx_q == BIT_IDX_FIRST_BYTE) begin
              held_d  = shift_next;
              shift_d = '0;
            end else begin
              shift_d = shift_next;
            end
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      low_len_q   <= '0;
      shift_q     <= '0;
      held_q      <= '0;
      bit_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      low_len_q   <= low_len_d;
      shift_q     <= shift_d;
      held_q      <= held_d;
      bit_idx_q   <= bit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    first_q  <= first_d;
    second_q <= second_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign first_byte_o  = first_q;
  assign second_byte_o = second_q;

endmodule

/* hdl/ir_pulse_distance_decoder.sv */
// Top level of the pulse-distance IR frame decoder.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o | pin_level_i
//  out     | output    | out_valid_o/out_stall_i | status_o, first_byte_o, second_byte_o
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One sample is taken per cycle while in_stall_o is low; the front end turns edges
// into run events. An event passes the 4-entry queue and is decoded by the back end
// as it is popped; the queue entry and then the result register lie between the
// sample ending the frame and out_valid_o, and events waiting ahead or a held output
// delay the result. in_stall_o rises only when the queue is full, i.e. after a held output.
// Reset restores the register defaults and an idle line (previous level high).
module ir_pulse_distance_decoder import ipd_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 pin_level_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [7:0]           first_byte_o,
  output logic [7:0]           second_byte_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int EV_W = COUNT_BITS + 1;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEADER_LOW_MIN:  cfg_d.leader_low_min  = cfg_data_i;
        CFG_LEADER_LOW_MAX:  cfg_d.leader_low_max  = cfg_data_i;
        CFG_LEADER_HIGH_MIN: cfg_d.leader_high_min = cfg_data_i;
        CFG_LEADER_HIGH_MAX: cfg_d.leader_high_max = cfg_data_i;
        CFG_BIT_LOW_MIN:     cfg_d.bit_low_min     = cfg_data_i;
        CFG_ZERO_HIGH_MIN:   cfg_d.zero_high_min   = cfg_data_i;
        CFG_ZERO_HIGH_MAX:   cfg_d.zero_high_max   = cfg_data_i;
        CFG_ONE_HIGH_MIN:    cfg_d.one_high_min    = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low_min  <= RST_LEADER_LOW_MIN;
      cfg_q.leader_low_max  <= RST_LEADER_LOW_MAX;
      cfg_q.leader_high_min <= RST_LEADER_HIGH_MIN;
      cfg_q.leader_high_max <= RST_LEADER_HIGH_MAX;
      cfg_q.bit_low_min     <= RST_BIT_LOW_MIN;
      cfg_q.zero_high_min   <= RST_ZERO_HIGH_MIN;
      cfg_q.zero_high_max   <= RST_ZERO_HIGH_MAX;
      cfg_q.one_high_min    <= RST_ONE_HIGH_MIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                  fifo_full, push, pop, ev_valid;
  logic                  push_level;
  logic [COUNT_BITS-1:0] push_len;
  logic [EV_W-1:0]       head;

  ipd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .pin_level_i (pin_level_i),
    .fifo_full_i (fifo_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .ev_level_o  (push_level),
    .ev_len_o    (push_len)
  );

  ipd_fifo #(.DATA_W(EV_W)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_level, push_len}),
    .pop_i       (pop),
    .valid_o     (ev_valid),
    .head_o      (head),
    .full_o      (fifo_full)
  );

  ipd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .ev_valid_i    (ev_valid),
    .ev_level_i    (head[EV_W-1]),
    .ev_len_i      (head[COUNT_BITS-1:0]),
    .ev_pop_o      (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o)
  );

endmodule

/* hdl/ipd_checker.sv */
// Port-level checker for the decoder, bound to the top level.
`include "assert_macros.svh"

module ipd_checker import ipd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] first_byte_o,
  input logic [7:0] second_byte_o
);

  `IPD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(first_byte_o) && $stable(second_byte_o), "stalled result changed")

  `IPD_ASSERT(a_err_bytes_zero, out_valid_o && (status_o != ST_OK) |-> (first_byte_o == 8'd0) && (second_byte_o == 8'd0), "error result carries data")

  `IPD_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i), "input stalled without a held result")

  `IPD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

bind ir_pulse_distance_decoder ipd_checker u_ipd_checker (.*);
